// ===== sv/btc3_pkg.sv =====
// ----------------------------------------------------------------------------
// btc3_pkg
// Shared types, constants and helpers of the binary 3x3 cross top-hat block.
// ----------------------------------------------------------------------------
package btc3_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int MIN_DIM        = 3;
  localparam int CFG_W          = 11;
  localparam int DIM_W          = 13;
  localparam int PIX_W          = 8;

  localparam logic [CFG_W-1:0] RST_WIDTH  = 11'd768;
  localparam logic [CFG_W-1:0] RST_HEIGHT = 11'd576;
  localparam logic [PIX_W-1:0] FG_LEVEL   = 8'hFF;

  typedef enum logic {
    ACT_PIXEL = 1'b0,
    ACT_DRAIN = 1'b1
  } action_t;

  typedef enum logic {
    CFG_IDX_WIDTH  = 1'b0,
    CFG_IDX_HEIGHT = 1'b1
  } cfg_idx_t;

  // border and output flags of one step of the stream
  typedef struct packed {
    logic fg_top;   // fg column: centre row is the first line
    logic fg_bot;   // fg column: centre row is the last line
    logic ero_l;    // erosion centre in the first column
    logic ero_r;    // erosion centre in the last column
    logic er_top;
    logic er_bot;
    logic dil_l;
    logic dil_r;
    logic emit;
    logic last;
  } step_flags_t;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             last;
  } result_t;

  function automatic logic [DIM_W-1:0] sat_dim(input logic [CFG_W-1:0] v,
                                               input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] ve;
    ve = DIM_W'(v);
    if (ve < DIM_W'(MIN_DIM)) return DIM_W'(MIN_DIM);
    if (ve > hi) return hi;
    return ve;
  endfunction

endpackage

// ===== sv/btc3_erode.sv =====
// ----------------------------------------------------------------------------
// btc3_erode
// Foreground line memory and 3x3 cross erosion over the pixel stream.
// ----------------------------------------------------------------------------
module btc3_erode #(
  parameter int MAX_WIDTH = btc3_pkg::DEF_MAX_WIDTH,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic                  clk,
  input  logic                  s0_step,
  input  logic [AW-1:0]         s0_col,
  input  logic                  s1_step,
  input  logic [AW-1:0]         s1_col,
  input  logic                  s1_fg,
  input  btc3_pkg::step_flags_t s1_flags,
  output logic                  erode_bit
);

  // each word holds column c of the two previous lines: [1] newer, [0] older
  logic [1:0] fg_mem [MAX_WIDTH];
  logic [1:0] rd_r;
  logic       vand1_r, mid1_r, mid2_r;
  logic       top, mid, bot, vand;

  always_ff @(posedge clk) begin
    if (s0_step) rd_r <= fg_mem[s0_col];
    if (s1_step) fg_mem[s1_col] <= {s1_fg, mid};
  end

  always_comb begin
    mid  = rd_r[1];
    top  = s1_flags.fg_top ? mid : rd_r[0];
    bot  = s1_flags.fg_bot ? mid : s1_fg;
    vand = top & mid & bot;
    erode_bit = vand1_r & (s1_flags.ero_l ? mid1_r : mid2_r)
                        & (s1_flags.ero_r ? mid1_r : mid);
  end

  always_ff @(posedge clk) begin
    if (s1_step) begin
      vand1_r <= vand;
      mid1_r  <= mid;
      mid2_r  <= mid1_r;
    end
  end

endmodule

// ===== sv/btc3_dilate.sv =====
// ----------------------------------------------------------------------------
// btc3_dilate
// Eroded line memory, cross dilation and pixel delay, giving the top-hat.
// ----------------------------------------------------------------------------
module btc3_dilate #(
  parameter int MAX_WIDTH = btc3_pkg::DEF_MAX_WIDTH,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic                          clk,
  input  logic                          s0_step,
  input  logic [AW-1:0]                 s0_col,
  input  logic [AW-1:0]                 s0_ecol,
  input  logic                          s1_step,
  input  logic [AW-1:0]                 s1_col,
  input  logic [AW-1:0]                 s1_ecol,
  input  logic [btc3_pkg::PIX_W-1:0]    s1_pixel,
  input  btc3_pkg::step_flags_t         s1_flags,
  input  logic                          erode_bit,
  output logic [btc3_pkg::PIX_W-1:0]    tophat
);

  logic [1:0]                     er_mem [MAX_WIDTH];
  logic [2*btc3_pkg::PIX_W-1:0]   px_mem [MAX_WIDTH];
  logic [1:0]                     erd_r;
  logic [2*btc3_pkg::PIX_W-1:0]   prd_r;
  logic                           vor1_r, mid1_r, mid2_r;
  logic [btc3_pkg::PIX_W-1:0]     pd1_r, pd2_r;
  logic                           top, mid, bot, vor, opened;

  always_ff @(posedge clk) begin
    if (s0_step) begin
      erd_r <= er_mem[s0_ecol];
      prd_r <= px_mem[s0_col];
    end
    if (s1_step) begin
      er_mem[s1_ecol] <= {erode_bit, mid};
      px_mem[s1_col]  <= {s1_pixel, prd_r[2*btc3_pkg::PIX_W-1:btc3_pkg::PIX_W]};
    end
  end

  always_comb begin
    mid    = erd_r[1];
    top    = s1_flags.er_top ? mid : erd_r[0];
    bot    = s1_flags.er_bot ? mid : erode_bit;
    vor    = top | mid | bot;
    opened = vor1_r | (s1_flags.dil_l ? mid1_r : mid2_r)
                    | (s1_flags.dil_r ? mid1_r : mid);
    // pixel minus 255 never stays above zero
    tophat = opened ? '0 : pd2_r;
  end

  always_ff @(posedge clk) begin
    if (s1_step) begin
      vor1_r <= vor;
      mid1_r <= mid;
      mid2_r <= mid1_r;
      pd1_r  <= prd_r[btc3_pkg::PIX_W-1:0];
      pd2_r  <= pd1_r;
    end
  end

endmodule

// ===== sv/binary_tophat_cross3x3.sv =====
// Path: each accepted item is registered in stage 1, each result in the output buffer;
// in stream terms it follows its pixel by 2*W+2 items, the last ones by drain items.
// Throughput: one item per cycle while results are taken, set by one read and one
// write-back per cycle on each column-wide line memory and a two-entry output buffer.
// Reset: counters and output buffer clear, frame size takes its reset value; the
// line memories are not cleared, only entries written in the current frame are used.
// ----------------------------------------------------------------------------
// binary_tophat_cross3x3
// Streaming white top-hat of a binary image with a 3x3 cross.
// ----------------------------------------------------------------------------
module binary_tophat_cross3x3 #(
  parameter int MAX_WIDTH  = btc3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = btc3_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_action,
  input  logic [btc3_pkg::PIX_W-1:0]     in_pixel,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [btc3_pkg::PIX_W-1:0]     out_tophat_value,
  output logic                           out_frame_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [btc3_pkg::CFG_W-1:0]     cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int DW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 3);

  logic [btc3_pkg::CFG_W-1:0] cfg_w_r, cfg_h_r;
  logic [DW-1:0]              fw_r, fw;
  logic [HW-1:0]              fh_r, fh;
  logic [AW-1:0]              col_r, col_nxt, ecol;
  logic [RW-1:0]              row_r, row_nxt, h_ext;
  logic                       start, step, is_pixel, col_wrap;
  btc3_pkg::step_flags_t      flags;

  logic                       s1_v_r;
  logic [AW-1:0]              s1_col_r, s1_ecol_r;
  logic                       s1_fg_r;
  logic [btc3_pkg::PIX_W-1:0] s1_pix_r;
  btc3_pkg::step_flags_t      s1_flags_r;
  logic                       erode_bit;
  logic [btc3_pkg::PIX_W-1:0] tophat;

  btc3_pkg::result_t          q0_r, q1_r, push_res;
  logic [1:0]                 cnt_r, cnt_nxt;
  logic                       push, pop, slot;
  logic [2:0]                 occ;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r <= btc3_pkg::RST_WIDTH;
      cfg_h_r <= btc3_pkg::RST_HEIGHT;
    end else if (cfg_valid) begin
      unique case (btc3_pkg::cfg_idx_t'(cfg_index))
        btc3_pkg::CFG_IDX_WIDTH:  cfg_w_r <= cfg_data;
        btc3_pkg::CFG_IDX_HEIGHT: cfg_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stream position and border flags
  always_comb begin
    is_pixel = (btc3_pkg::action_t'(in_action) == btc3_pkg::ACT_PIXEL);
    start    = is_pixel && (row_r == '0) && (col_r == '0);
    fw = start ? DW'(btc3_pkg::sat_dim(cfg_w_r, btc3_pkg::DIM_W'(MAX_WIDTH))) : fw_r;
    fh = start ? HW'(btc3_pkg::sat_dim(cfg_h_r, btc3_pkg::DIM_W'(MAX_HEIGHT))) : fh_r;
    h_ext = RW'(fh);
    step = in_valid && in_ready && (is_pixel ? (row_r < h_ext) : (row_r >= h_ext));
    ecol = (col_r == '0) ? AW'(fw - DW'(1)) : col_r - AW'(1);

    flags.fg_top = (row_r == RW'(1));
    flags.fg_bot = (row_r == h_ext);
    flags.ero_l  = (col_r == AW'(1));
    flags.ero_r  = (col_r == '0);
    flags.er_top = (col_r != '0) ? (row_r == RW'(2)) : (row_r == RW'(3));
    flags.er_bot = (col_r != '0) ? (row_r == h_ext + RW'(1)) : (row_r == h_ext + RW'(2));
    flags.dil_l  = (col_r == AW'(2));
    flags.dil_r  = (col_r == AW'(1));
    flags.emit   = (row_r > RW'(2)) || ((row_r == RW'(2)) && (col_r >= AW'(2)));
    flags.last   = (row_r == h_ext + RW'(2)) && (col_r == AW'(1));

    col_wrap = (DW'(col_r) + DW'(1)) == fw;
    col_nxt  = col_r;
    row_nxt  = row_r;
    if (step) begin
      if (flags.last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_wrap) begin
        col_nxt = '0;
        row_nxt = row_r + RW'(1);
      end else begin
        col_nxt = col_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      fw_r   <= DW'(btc3_pkg::MIN_DIM);
      fh_r   <= HW'(btc3_pkg::MIN_DIM);
      s1_v_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      s1_v_r <= step;
      if (step) begin
        fw_r <= fw;
        fh_r <= fh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      s1_col_r   <= col_r;
      s1_ecol_r  <= ecol;
      s1_fg_r    <= (in_pixel == btc3_pkg::FG_LEVEL);
      s1_pix_r   <= in_pixel;
      s1_flags_r <= flags;
    end
  end

  btc3_erode #(.MAX_WIDTH(MAX_WIDTH)) u_erode (
    .clk       (clk),
    .s0_step   (step),
    .s0_col    (col_r),
    .s1_step   (s1_v_r),
    .s1_col    (s1_col_r),
    .s1_fg     (s1_fg_r),
    .s1_flags  (s1_flags_r),
    .erode_bit (erode_bit)
  );

  btc3_dilate #(.MAX_WIDTH(MAX_WIDTH)) u_dilate (
    .clk       (clk),
    .s0_step   (step),
    .s0_col    (col_r),
    .s0_ecol   (ecol),
    .s1_step   (s1_v_r),
    .s1_col    (s1_col_r),
    .s1_ecol   (s1_ecol_r),
    .s1_pixel  (s1_pix_r),
    .s1_flags  (s1_flags_r),
    .erode_bit (erode_bit),
    .tophat    (tophat)
  );

  // two-entry output buffer, room kept for the item in flight
  always_comb begin
    push           = s1_v_r && s1_flags_r.emit;
    push_res.value = tophat;
    push_res.last  = s1_flags_r.last;
    pop            = (cnt_r != 2'd0) && out_ready;
    occ            = 3'(cnt_r) + 3'(s1_v_r) - 3'(pop);
    in_ready       = (occ <= 3'd1);
    cnt_nxt        = 2'(3'(cnt_r) + 3'(push) - 3'(pop));
    slot           = (2'(cnt_r - 2'(pop)) != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !slot) q0_r <= push_res;
    else if (pop) q0_r <= q1_r;
    if (push && slot) q1_r <= push_res;
  end

  assign out_valid        = (cnt_r != 2'd0);
  assign out_tophat_value = q0_r.value;
  assign out_frame_last   = q0_r.last;

endmodule

// ===== sv/btc3_checker.sv =====
// ----------------------------------------------------------------------------
// btc3_checker
// Port-level checks of the top-hat block, bound to the top level.
// ----------------------------------------------------------------------------
module btc3_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_action,
  input logic [btc3_pkg::PIX_W-1:0] in_pixel,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [btc3_pkg::PIX_W-1:0] out_tophat_value,
  input logic                       out_frame_last,
  input logic                       cfg_valid,
  input logic                       cfg_ready,
  input logic                       cfg_index,
  input logic [btc3_pkg::CFG_W-1:0] cfg_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tophat_value)
                                && $stable(out_frame_last))
    else $error("result changed while stalled");

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // input only stalls behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  // a fresh result always follows an accepted item, via stage 1 and the output buffer
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a causing item");

endmodule

bind binary_tophat_cross3x3 btc3_checker u_btc3_checker (.*);
